// ===== hw/rtl/button_debounce_press_classifier_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce and press classifier
// Shared helpers for concurrent checks clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication
`define BDPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdpc assertion failed");

// next-cycle implication
`define BDPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdpc assertion failed");

`endif

// ===== hw/rtl/bdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpc_pkg
// Types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd15;
  localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd1000;
  localparam logic [CFG_W-1:0] LONG_RST      = 16'd3000;

  typedef enum logic [IDX_W-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_SHORT_MAX = 2'd1,
    REG_LONG      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] short_max_ms;
    logic [CFG_W-1:0] long_ms;
  } cfg_t;

  typedef struct packed {
    logic stable_level;
    logic press_event;
    logic release_event;
    logic short_press_event;
    logic long_press_event;
  } result_t;

endpackage

// ===== hw/rtl/bdpc_if.sv =====
// ----------------------------------------------------------------------------
// bdpc_if
// Valid/ready channels for polls in and classified results out.
// ----------------------------------------------------------------------------
interface bdpc_in_if
  import bdpc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              raw_level;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output raw_level, output now_ms, input ready);
  modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bdpc_out_if;
  logic valid;
  logic ready;
  logic stable_level;
  logic press_event;
  logic release_event;
  logic short_press_event;
  logic long_press_event;

  modport source (output valid, output stable_level, output press_event,
                  output release_event, output short_press_event,
                  output long_press_event, input ready);
  modport sink   (input valid, input stable_level, input press_event,
                  input release_event, input short_press_event,
                  input long_press_event, output ready);
endinterface

// ===== hw/rtl/bdpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bdpc_cfg_regs
// Timing limit registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bdpc_cfg_regs
  import bdpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms  <= DEBOUNCE_RST;
      cfg.short_max_ms <= SHORT_MAX_RST;
      cfg.long_ms      <= LONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:  cfg.debounce_ms  <= cfg_data;
        REG_SHORT_MAX: cfg.short_max_ms <= cfg_data;
        REG_LONG:      cfg.long_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bdpc_eval.sv =====
// ----------------------------------------------------------------------------
// bdpc_eval
// Debounce and press state; evaluates one poll and updates on step.
// ----------------------------------------------------------------------------
module bdpc_eval
  import bdpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              raw_level,
  input  logic [TIME_W-1:0] now_ms,
  input  cfg_t              cfg,
  output result_t           res
);

  logic              last_sample;
  logic              debounce_active;
  logic [TIME_W-1:0] change_time;
  logic              accepted_level;
  logic [TIME_W-1:0] press_time;
  logic              long_armed;

  logic              raw_change;
  logic [TIME_W-1:0] dbn_elapsed;
  logic [TIME_W-1:0] hold;
  logic              accept;
  logic              lvl_change;
  logic              press_ev;
  logic              release_ev;
  logic              short_ev;
  logic              long_ev;
  logic              long_armed_next;

  always_comb begin
    raw_change  = raw_level != last_sample;
    dbn_elapsed = now_ms - change_time;
    hold        = now_ms - press_time;
    accept      = !raw_change && debounce_active &&
                  (dbn_elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms});
    lvl_change  = accept && (last_sample != accepted_level);
    press_ev    = lvl_change && !last_sample;
    release_ev  = lvl_change && last_sample;
    short_ev    = release_ev &&
                  (hold <= {{(TIME_W-CFG_W){1'b0}}, cfg.short_max_ms});
    // a press restarts the hold at zero
    if (press_ev) begin
      long_ev = cfg.long_ms == '0;
    end else begin
      long_ev = long_armed && !release_ev &&
                (hold >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_ms});
    end
    if (press_ev) begin
      long_armed_next = !long_ev;
    end else if (release_ev || long_ev) begin
      long_armed_next = 1'b0;
    end else begin
      long_armed_next = long_armed;
    end

    res.stable_level      = accept ? last_sample : accepted_level;
    res.press_event       = press_ev;
    res.release_event     = release_ev;
    res.short_press_event = short_ev;
    res.long_press_event  = long_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample     <= 1'b1;
      debounce_active <= 1'b0;
      change_time     <= '0;
      accepted_level  <= 1'b1;
      press_time      <= '0;
      long_armed      <= 1'b0;
    end else if (step) begin
      last_sample <= raw_level;
      if (raw_change) begin
        debounce_active <= 1'b1;
        change_time     <= now_ms;
      end else if (accept) begin
        debounce_active <= 1'b0;
      end
      accepted_level <= res.stable_level;
      if (press_ev) begin
        press_time <= now_ms;
      end
      long_armed <= long_armed_next;
    end
  end

endmodule

// ===== hw/rtl/button_debounce_press_classifier_core.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_core
// Debounces an active-low button poll stream and flags press, release,
// short-press and long-press events. One poll is taken every clock cycle
// while the result output is not stalled; each poll passes through the poll
// register, then the result register. The single-pass evaluation of a poll
// against the debounce and press state sets that rate, and the result
// register lets a new poll enter while a result waits to be taken.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_core
  import bdpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  bdpc_in_if.sink          sample,
  bdpc_out_if.source       result,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t              cfg;
  logic              in_valid;
  logic              in_raw;
  logic [TIME_W-1:0] in_now;
  logic              out_valid;
  result_t           out_res;
  result_t           res;
  logic              advance;
  logic              sample_fire;

  assign advance     = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;
  assign sample_fire = sample.valid && sample.ready;

  bdpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdpc_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .raw_level (in_raw),
    .now_ms    (in_now),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_valid  <= sample_fire || (in_valid && !advance);
      out_valid <= advance || (out_valid && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (sample_fire) begin
      in_raw <= sample.raw_level;
      in_now <= sample.now_ms;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign result.valid             = out_valid;
  assign result.stable_level      = out_res.stable_level;
  assign result.press_event       = out_res.press_event;
  assign result.release_event     = out_res.release_event;
  assign result.short_press_event = out_res.short_press_event;
  assign result.long_press_event  = out_res.long_press_event;

endmodule

// ===== hw/rtl/bdpc_checker.sv =====
// ----------------------------------------------------------------------------
// bdpc_checker
// Port-level checks on result transactions of the classifier core.
// ----------------------------------------------------------------------------
`include "button_debounce_press_classifier_core_assert.svh"

module bdpc_checker (
  input logic clk,
  input logic rst,
  input logic result_valid,
  input logic result_ready,
  input logic stable_level,
  input logic press_event,
  input logic release_event,
  input logic short_press_event,
  input logic long_press_event
);

  logic [4:0] result_bits;

  assign result_bits = {stable_level, press_event, release_event, short_press_event,
                        long_press_event};

  `BDPC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_bits))
  `BDPC_ASSERT_IMPL(a_press_level, result_valid && press_event, !stable_level && !release_event)
  `BDPC_ASSERT_IMPL(a_release_level, result_valid && release_event, stable_level && !long_press_event)
  `BDPC_ASSERT_IMPL(a_short_on_release, result_valid && short_press_event, release_event)

endmodule

bind button_debounce_press_classifier_core bdpc_checker u_bdpc_checker (
  .clk               (clk),
  .rst               (rst),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .stable_level      (result.stable_level),
  .press_event       (result.press_event),
  .release_event     (result.release_event),
  .short_press_event (result.short_press_event),
  .long_press_event  (result.long_press_event)
);
